// ===== rtl/cso_pkg.sv =====
// shared types and constants for the cursor sprite overlay
package cso_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_W = 3;
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_CURSOR_X  = 3'd0,
        REG_CURSOR_Y  = 3'd1,
        REG_HOT_X     = 3'd2,
        REG_HOT_Y     = 3'd3,
        REG_COLOR_KEY = 3'd4
    } cfg_reg_t;

    // item kinds carried on the input tuser
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // field widths
    localparam int CFG_DATA_W = 24;
    localparam int POS_W      = 13;
    localparam int HOT_W      = 4;
    localparam int KEY_W      = 24;
    localparam int INDEX_W    = 8;
    localparam int WORD_W     = 32;
    localparam int COORD_W    = 12;
    // sprite-relative coordinate: 12-bit unsigned minus 13-bit signed plus 4-bit
    localparam int REL_W      = 15;

    // reset values
    localparam logic [HOT_W-1:0] HOT_X_RESET     = 4'd3;
    localparam logic [HOT_W-1:0] HOT_Y_RESET     = 4'd4;
    localparam logic [KEY_W-1:0] COLOR_KEY_RESET = 24'h00FF00;

    // live configuration
    typedef struct packed {
        logic signed [POS_W-1:0] cursor_x;
        logic signed [POS_W-1:0] cursor_y;
        logic [HOT_W-1:0]        hot_x;
        logic [HOT_W-1:0]        hot_y;
        logic [KEY_W-1:0]        color_key;
    } cfg_t;

endpackage

// ===== rtl/cso_ram.sv =====
// generic single-write, single-read synchronous ram with registered read
module cso_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 160,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cso_map.sv =====
// maps a frame pixel position onto a sprite texel address
module cso_map #(
    parameter int SPRITE_ROWS = 16,
    parameter int SPRITE_COLS = 10,
    parameter int ADDR_W      = 8
) (
    input  cso_pkg::cfg_t                cfg,
    input  logic [cso_pkg::COORD_W-1:0]  pixel_x,
    input  logic [cso_pkg::COORD_W-1:0]  pixel_y,
    output logic                         in_sprite,
    output logic [ADDR_W-1:0]            addr
);

    logic signed [cso_pkg::REL_W-1:0] col;
    logic signed [cso_pkg::REL_W-1:0] row;
    logic [ADDR_W-1:0]                row_a;
    logic [ADDR_W-1:0]                col_a;

    // sprite-relative column and row
    always_comb
    begin
        col = $signed({3'b000, pixel_x}) - cso_pkg::REL_W'(cfg.cursor_x)
            + $signed({11'd0, cfg.hot_x});
        row = $signed({3'b000, pixel_y}) - cso_pkg::REL_W'(cfg.cursor_y)
            + $signed({11'd0, cfg.hot_y});
    end

    // bounds check against the sprite size
    assign in_sprite = (col >= 0) && (col < cso_pkg::REL_W'(SPRITE_COLS))
                    && (row >= 0) && (row < cso_pkg::REL_W'(SPRITE_ROWS));

    // row-major texel address, meaningful only when inside
    assign row_a = ADDR_W'(row);
    assign col_a = ADDR_W'(col);
    assign addr  = ADDR_W'(row_a * ADDR_W'(SPRITE_COLS)) + col_a;

endmodule

// ===== rtl/cursor_sprite_overlay.sv =====
// top level of the cursor sprite overlay with color key
//
// Takes one item per clock on the input stream and keeps that rate as long as
// the output side is ready. A load item (tuser 0) writes one texel into the
// sprite ram and yields no output; a pixel item (tuser 1) yields exactly one
// output transfer: the sprite ram read goes through its registered read port
// while the pixel waits in the lookup stage, and then comes the color key
// compare into the output register. Every texel the cursor can cover must be
// loaded before pixels flow. A load followed directly by a pixel reading the
// same texel sees the new value. Configuration writes are taken at any time
// but must only be issued while no pixel is in flight.
module cursor_sprite_overlay #(
    parameter int SPRITE_ROWS = 16,
    parameter int SPRITE_COLS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [cso_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [cso_pkg::CFG_DATA_W-1:0]     cfg_data,
    // input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // sprite_index[7:0], data_word[39:8], pixel_x[51:40], pixel_y[63:52]
    input  logic [63:0]                        s_tdata,
    // command[0]
    input  logic                               s_tuser,
    // output stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_pixel[31:0]
    output logic [31:0]                        m_tdata,
    // cursor_hit[0]
    output logic                               m_tuser
);

    localparam int DEPTH  = SPRITE_ROWS * SPRITE_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cso_pkg::cfg_t                   cfg_reg;
    logic [cso_pkg::INDEX_W-1:0]     in_index;
    logic [cso_pkg::WORD_W-1:0]      in_word;
    logic [cso_pkg::COORD_W-1:0]     in_x;
    logic [cso_pkg::COORD_W-1:0]     in_y;
    logic                            s_xfer;
    logic                            load_we;
    logic                            pix_re;
    logic                            map_inside;
    logic [ADDR_W-1:0]               map_addr;
    logic [cso_pkg::WORD_W-1:0]      texel;

    logic                            b_valid_reg;
    logic                            b_inside_reg;
    logic [cso_pkg::WORD_W-1:0]      b_pixel_reg;
    logic                            b_advance;
    logic                            b_hit;

    logic                            out_valid_reg;
    logic [cso_pkg::WORD_W-1:0]      out_pixel_reg;
    logic                            out_hit_reg;

    // unpack input transfer
    assign in_index = s_tdata[7:0];
    assign in_word  = s_tdata[39:8];
    assign in_x     = s_tdata[51:40];
    assign in_y     = s_tdata[63:52];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cursor_x  <= '0;
            cfg_reg.cursor_y  <= '0;
            cfg_reg.hot_x     <= cso_pkg::HOT_X_RESET;
            cfg_reg.hot_y     <= cso_pkg::HOT_Y_RESET;
            cfg_reg.color_key <= cso_pkg::COLOR_KEY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cso_pkg::REG_CURSOR_X:  cfg_reg.cursor_x  <= cfg_data[cso_pkg::POS_W-1:0];
                cso_pkg::REG_CURSOR_Y:  cfg_reg.cursor_y  <= cfg_data[cso_pkg::POS_W-1:0];
                cso_pkg::REG_HOT_X:     cfg_reg.hot_x     <= cfg_data[cso_pkg::HOT_W-1:0];
                cso_pkg::REG_HOT_Y:     cfg_reg.hot_y     <= cfg_data[cso_pkg::HOT_W-1:0];
                cso_pkg::REG_COLOR_KEY: cfg_reg.color_key <= cfg_data[cso_pkg::KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake: lookup stage moves on when the output register frees up
    assign b_advance = !out_valid_reg || m_tready;
    assign s_tready  = !b_valid_reg || b_advance;
    assign s_xfer    = s_tvalid && s_tready;

    // loads beyond the store are dropped
    assign load_we = s_xfer && (s_tuser == cso_pkg::CMD_LOAD)
                  && (13'(in_index) < 13'(DEPTH));
    assign pix_re  = s_xfer && (s_tuser == cso_pkg::CMD_PIXEL);

    // position to texel address
    cso_map #(
        .SPRITE_ROWS (SPRITE_ROWS),
        .SPRITE_COLS (SPRITE_COLS),
        .ADDR_W      (ADDR_W)
    ) u_map (
        .cfg       (cfg_reg),
        .pixel_x   (in_x),
        .pixel_y   (in_y),
        .in_sprite (map_inside),
        .addr      (map_addr)
    );

    // sprite store
    cso_ram #(
        .WIDTH  (cso_pkg::WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sprite_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (ADDR_W'(in_index)),
        .wdata (in_word),
        .re    (pix_re),
        .raddr (map_addr),
        .rdata (texel)
    );

    // lookup stage: pixel waits here while the texel is read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (s_xfer)
        begin
            b_valid_reg <= pix_re;
        end
        else if (b_advance)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_re)
        begin
            b_inside_reg <= map_inside;
            b_pixel_reg  <= in_word;
        end
    end

    // color key test
    assign b_hit = b_inside_reg
                && (texel[cso_pkg::KEY_W-1:0] != cfg_reg.color_key);

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_advance)
        begin
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_advance && b_valid_reg)
        begin
            out_pixel_reg <= b_hit ? texel : b_pixel_reg;
            out_hit_reg   <= b_hit;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pixel_reg;
    assign m_tuser  = out_hit_reg;

    // a load never enters the lookup stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == cso_pkg::CMD_LOAD)) |=> !b_valid_reg)
        else $error("load transfer produced a lookup entry");

    // a pixel always occupies the lookup stage next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == cso_pkg::CMD_PIXEL)) |=> b_valid_reg)
        else $error("pixel transfer lost before lookup");

    // a waiting lookup entry is not overwritten while the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("input taken while lookup stage is blocked");

    // a hit never carries a keyed texel
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_hit_reg)
            |-> (out_pixel_reg[cso_pkg::KEY_W-1:0] != cfg_reg.color_key))
        else $error("transparent texel reported as hit");

endmodule
